// ===== src/tccw_pkg.sv =====
// Shared types and constants of the text console cell writer.
package tccw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int CODE_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int CELL_W     = 16;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'b1;

  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CFG_DATA_W-1:0] TEXT_ATTR_RST  = 8'h07;
  localparam logic [CFG_DATA_W-1:0] BLANK_ATTR_RST = 8'h0F;
  localparam logic [CELL_W-1:0]     CLEAR_CELL     = {BLANK_ATTR_RST, CH_SPACE};

  typedef struct packed {
    logic               op;
    logic [CODE_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tccw_in_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic                 scrolled;
  } tccw_res_t;

  typedef struct packed {
    logic wr_en;
    logic scroll;
  } tccw_cur_ctl_t;

endpackage

// ===== src/tccw_ram.sv =====
// Generic single write port RAM with registered read.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/tccw_cursor.sv =====
// Cursor update unit: interprets one character against the current cursor.
module tccw_cursor #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tccw_pkg::TAB_STEP_DEF,
  localparam int ROW_W = $clog2(ROWS + 1),
  localparam int COL_W = $clog2(COLUMNS + 1)
) (
  input  logic [ROW_W-1:0]            row_i,
  input  logic [COL_W-1:0]            col_i,
  input  logic [tccw_pkg::CODE_W-1:0] code_i,
  output tccw_pkg::tccw_cur_ctl_t     ctl_o,
  output logic [ROW_W-1:0]            wr_row_o,
  output logic [COL_W-1:0]            wr_col_o,
  output logic [tccw_pkg::CODE_W-1:0] wr_char_o,
  output logic [ROW_W-1:0]            new_row_o,
  output logic [COL_W-1:0]            new_col_o
);

  localparam int TW = COL_W + 2;

  logic [ROW_W-1:0] row_inc;
  logic [TW-1:0]    tab_sum;
  logic             bs;
  logic [COL_W-1:0] col_back;
  logic [COL_W-1:0] col_wrap;
  logic [ROW_W-1:0] row_wrap;
  logic [ROW_W-1:0] row_fin;

  assign row_inc = (row_i < ROW_W'(ROWS)) ? row_i + ROW_W'(1) : row_i;
  assign tab_sum = TW'(col_i) + TW'(TAB_STEP);
  assign bs      = (code_i == tccw_pkg::CH_BACKSPACE);

  always_comb begin
    ctl_o     = '0;
    wr_row_o  = row_i;
    wr_col_o  = col_i;
    wr_char_o = code_i;
    new_row_o = row_i;
    new_col_o = col_i;
    col_back  = col_i;
    col_wrap  = col_i;
    row_wrap  = row_i;
    row_fin   = row_i;
    case (code_i)
      tccw_pkg::CH_NEWLINE: begin
        new_row_o = row_inc;
        new_col_o = '0;
      end
      tccw_pkg::CH_TAB: begin
        new_col_o = (tab_sum > TW'(COLUMNS)) ? COL_W'(COLUMNS) : tab_sum[COL_W-1:0];
      end
      default: begin
        col_back = (bs && (col_i != '0)) ? col_i - COL_W'(1) : col_i;
        if (col_back >= COL_W'(COLUMNS)) begin
          col_wrap = '0;
          row_wrap = row_inc;
        end else begin
          col_wrap = col_back;
          row_wrap = row_i;
        end
        ctl_o.wr_en  = 1'b1;
        ctl_o.scroll = (row_wrap >= ROW_W'(ROWS));
        row_fin      = ctl_o.scroll ? ROW_W'(ROWS - 1) : row_wrap;
        wr_row_o     = row_fin;
        wr_col_o     = col_wrap;
        wr_char_o    = bs ? tccw_pkg::CH_SPACE : code_i;
        new_row_o    = row_fin;
        new_col_o    = bs ? col_wrap : col_wrap + COL_W'(1);
      end
    endcase
  end

endmodule

// ===== src/text_console_cell_writer.sv =====
// Top level of the text console cell writer: sequencer, cursor, screen store.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  command  | start_i / busy_o    | in_i  (op, char_code, cell_index)
//  result   | done_o (one cycle)  | res_o (cell_data, cursor_row/col, scrolled)
//  config   | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// A read or a put without scroll passes the sequencer step (ST_PUT or ST_READ)
// and then the registered result; done_o rises from done_q after that step.
// A put that scrolls passes ST_PUT, ST_COPY, ST_FILL and ST_LAST: the single memory
// write port copies one cell per cycle up a row, then fills the last row and the character.
// After reset a clearing pass writes COLUMNS*ROWS cells (2000) while busy_o is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module text_console_cell_writer #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  tccw_pkg::tccw_in_t                  in_i,
  output logic                                done_o,
  output tccw_pkg::tccw_res_t                 res_o,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_N     = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int CW         = tccw_pkg::CELL_W;
  localparam int RO_W       = tccw_pkg::ROW_OUT_W;
  localparam int CO_W       = tccw_pkg::COL_OUT_W;

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_COPY = 3'd4;
  localparam logic [2:0] ST_FILL = 3'd5;
  localparam logic [2:0] ST_LAST = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic [7:0]        text_attr_q, blank_attr_q;

  logic [ADDR_W-1:0]           wptr_q;
  logic [COL_W-1:0]            wcol_q, wcol_d;
  logic [tccw_pkg::CODE_W-1:0] char_q, char_d;
  logic                        rd_ok_q;
  tccw_pkg::tccw_res_t         res_q, res_d;

  tccw_pkg::tccw_cur_ctl_t     cu_ctl;
  logic [ROW_W-1:0]            cu_wr_row, cu_new_row;
  logic [COL_W-1:0]            cu_wr_col, cu_new_col;
  logic [tccw_pkg::CODE_W-1:0] cu_char;

  logic              accept;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [ADDR_W-1:0] cell_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0]     ram_wdata, ram_rdata;

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STEP(TAB_STEP)
  ) u_cursor (
    .row_i    (row_q),
    .col_i    (col_q),
    .code_i   (char_q),
    .ctl_o    (cu_ctl),
    .wr_row_o (cu_wr_row),
    .wr_col_o (cu_wr_col),
    .wr_char_o(cu_char),
    .new_row_o(cu_new_row),
    .new_col_o(cu_new_col)
  );

  tccw_ram #(
    .WIDTH(CW),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = done_q;
  assign res_o  = res_q;

  assign sel_row   = (state_q == ST_LAST) ? row_q  : cu_wr_row;
  assign sel_col   = (state_q == ST_LAST) ? wcol_q : cu_wr_col;
  assign cell_addr = ADDR_W'(sel_row) * COLS_A + ADDR_W'(sel_col);
  assign ram_raddr = (state_q == ST_COPY) ? cnt_q + COLS_A : ADDR_W'(in_i.cell_index);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = {blank_attr_q, tccw_pkg::CH_SPACE};
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = tccw_pkg::CLEAR_CELL;
      end
      ST_PUT: begin
        ram_we    = cu_ctl.wr_en && !cu_ctl.scroll;
        ram_waddr = cell_addr;
        ram_wdata = {text_attr_q, cu_char};
      end
      ST_COPY: begin
        ram_we    = pend_q;
        ram_waddr = wptr_q;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr;
        ram_wdata = {text_attr_q, char_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    col_d   = col_q;
    pend_d  = 1'b0;
    done_d  = 1'b0;
    wcol_d  = wcol_q;
    char_d  = char_q;
    res_d   = res_q;
    case (state_q)
      ST_CLR: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        char_d = in_i.char_code;
        if (accept) begin
          state_d = (in_i.op == tccw_pkg::OP_READ) ? ST_READ : ST_PUT;
        end
      end
      ST_PUT: begin
        if (cu_ctl.wr_en && cu_ctl.scroll) begin
          row_d   = cu_new_row;
          col_d   = cu_new_col;
          wcol_d  = cu_wr_col;
          char_d  = cu_char;
          cnt_d   = '0;
          state_d = ST_COPY;
        end else begin
          row_d            = cu_new_row;
          col_d            = cu_new_col;
          res_d.cell_data  = '0;
          res_d.cursor_row = RO_W'(cu_new_row);
          res_d.cursor_col = CO_W'(cu_new_col);
          res_d.scrolled   = 1'b0;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_READ: begin
        res_d.cell_data  = rd_ok_q ? ram_rdata : '0;
        res_d.cursor_row = RO_W'(row_q);
        res_d.cursor_col = CO_W'(col_q);
        res_d.scrolled   = 1'b0;
        done_d           = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        if (cnt_q < ADDR_W'(COPY_N)) begin
          cnt_d  = cnt_q + ADDR_W'(1);
          pend_d = 1'b1;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        res_d.cell_data  = '0;
        res_d.cursor_row = RO_W'(row_q);
        res_d.cursor_col = CO_W'(col_q);
        res_d.scrolled   = 1'b1;
        done_d           = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= tccw_pkg::TEXT_ATTR_RST;
      blank_attr_q <= tccw_pkg::BLANK_ATTR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccw_pkg::CFG_TEXT_ATTR:  text_attr_q  <= cfg_wdata_i;
        tccw_pkg::CFG_BLANK_ATTR: blank_attr_q <= cfg_wdata_i;
        default: begin
          text_attr_q <= text_attr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= cnt_q;
    wcol_q <= wcol_d;
    char_q <= char_d;
    res_q  <= res_d;
    if (state_q == ST_IDLE) begin
      rd_ok_q <= (32'(in_i.cell_index) < 32'(CELL_COUNT));
    end
  end

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_PUT || $past(state_q) == ST_READ ||
                $past(state_q) == ST_LAST))
    else $error("result strobe without a finishing step");

  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_W'(ROWS)) && (col_q <= COL_W'(COLUMNS)))
    else $error("cursor out of range");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY || state_q == ST_FILL || state_q == ST_LAST) |->
      (row_q == ROW_W'(ROWS - 1)))
    else $error("scroll with cursor off the last row");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("transaction accepted without going busy");

endmodule
